// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertions on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define QJEM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds.
`define QJEM_NEVER(lbl, cond, msg) \
  `QJEM_ASSERT(lbl, !(cond), msg)

`endif

// ===== hw/rtl/qjem_pkg.sv =====
// ---------------------------------------------------------------------------
// qjem_pkg
// Types and constants shared by the quaternion Julia escape metric block.
// ---------------------------------------------------------------------------
package qjem_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_C_X   = 3'd0,
    CFG_C_Y   = 3'd1,
    CFG_C_Z   = 3'd2,
    CFG_C_W   = 3'd3,
    CFG_LIMIT = 3'd4,
    CFG_LEVEL = 3'd5,
    CFG_MODE  = 3'd6
  } cfg_idx_e;

  // Metric modes; any code at or above magnitude selects magnitude
  localparam logic [1:0] MODE_PATH = 2'd0;
  localparam logic [1:0] MODE_DISP = 2'd1;
  localparam logic [1:0] MODE_MAG  = 2'd2;

  localparam logic [30:0] NormMax = '1;

  typedef struct packed {
    logic signed [31:0] z_x;
    logic signed [31:0] z_y;
    logic signed [31:0] z_z;
    logic signed [31:0] z_w;
  } in_t;

  typedef struct packed {
    logic [30:0] metric;
    logic [15:0] iterations_done;
    logic        escaped;
  } out_t;

  typedef struct packed {
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
    logic signed [31:0] c_w;
    logic [15:0]        iteration_limit;
    logic [30:0]        escape_level;
    logic [1:0]         metric_mode;
  } cfg_t;

  // Multiplier operations: quaternion square terms, then norm squares
  typedef enum logic [3:0] {
    OP_NONE,
    OP_XX,
    OP_YY,
    OP_ZZ,
    OP_WW,
    OP_XY,
    OP_XZ,
    OP_XW,
    OP_SQ0,
    OP_SQ1,
    OP_SQ2,
    OP_SQ3
  } op_e;

  // Vector fed to the norm
  typedef enum logic [1:0] {
    SRC_DIFF,
    SRC_DISP,
    SRC_MAG
  } nsrc_e;

  typedef struct packed {
    logic  load;
    op_e   op;
    logic  acc_init;
    logic  cur_upd;
    nsrc_e src;
    logic  sum_clr;
    logic  root_start;
    logic  path_add;
    logic  metric_take;
    logic  res_load;
  } cmd_t;

  typedef struct packed {
    logic root_done;
    logic limit_hit;
    logic esc_hit;
  } sts_t;

endpackage

// ===== hw/rtl/qjem_isqrt.sv =====
// ---------------------------------------------------------------------------
// qjem_isqrt
// Integer square root, two radicand bits per cycle.
// ---------------------------------------------------------------------------
module qjem_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic [30:0] root_o
);

  logic [63:0] v_q, res_q, bit_q;
  logic        busy_q, done_q;
  logic [63:0] trial;

  assign trial = res_q + bit_q;

  // Hold control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q == 64'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Advance one restoring step per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      res_q <= '0;
      bit_q <= 64'd1 << 60;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[30:0];

endmodule

// ===== hw/rtl/qjem_datapath.sv =====
// ---------------------------------------------------------------------------
// qjem_datapath
// Point registers, shared multiplier, accumulators, norm and result register.
// ---------------------------------------------------------------------------
module qjem_datapath #(
  parameter int unsigned FRACTION_BITS = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  qjem_pkg::cfg_t cfg_i,
  input  qjem_pkg::in_t  in_data_i,
  input  qjem_pkg::cmd_t cmd_i,
  output qjem_pkg::sts_t sts_o,
  output qjem_pkg::out_t out_data_o
);
  import qjem_pkg::*;

  logic signed [31:0] start_q [4];
  logic signed [31:0] cur_q [4];
  logic signed [31:0] prev_q [4];
  logic signed [63:0] acc_q [4];
  logic signed [63:0] p_q;
  op_e                op_q;
  logic               big_q;
  logic [63:0]        sum_q;
  logic               sat_q;
  logic [30:0]        path_q;
  logic [30:0]        metric_q;
  logic [15:0]        count_q;
  out_t               res_q;

  logic signed [31:0] in_z [4];
  logic signed [31:0] mag [4];
  logic               big [4];
  logic signed [31:0] mul_a, mul_b;
  logic               mul_big;
  logic signed [63:0] pf, pf2;
  logic [63:0]        sum_d;
  logic               root_done;
  logic [30:0]        root;
  logic [30:0]        norm_val;
  logic [31:0]        path_sum;
  logic [30:0]        path_d;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      return -32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  assign in_z[0] = in_data_i.z_x;
  assign in_z[1] = in_data_i.z_y;
  assign in_z[2] = in_data_i.z_z;
  assign in_z[3] = in_data_i.z_w;

  // Form each norm component exactly, then its magnitude
  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic signed [32:0] sub, d;
    logic [32:0]        a;
    always_comb begin
      unique case (cmd_i.src)
        SRC_DIFF: sub = 33'(prev_q[k]);
        SRC_DISP: sub = 33'(start_q[k]);
        default:  sub = '0;
      endcase
      d      = 33'(cur_q[k]) - sub;
      a      = d[32] ? 33'(-d) : 33'(d);
      big[k] = a[32:31] != 2'b00;
      mag[k] = {1'b0, a[30:0]};
    end
  end

  // Select multiplier operands
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_big = 1'b0;
    unique case (cmd_i.op)
      OP_XX:  begin mul_a = cur_q[0]; mul_b = cur_q[0]; end
      OP_YY:  begin mul_a = cur_q[1]; mul_b = cur_q[1]; end
      OP_ZZ:  begin mul_a = cur_q[2]; mul_b = cur_q[2]; end
      OP_WW:  begin mul_a = cur_q[3]; mul_b = cur_q[3]; end
      OP_XY:  begin mul_a = cur_q[0]; mul_b = cur_q[1]; end
      OP_XZ:  begin mul_a = cur_q[0]; mul_b = cur_q[2]; end
      OP_XW:  begin mul_a = cur_q[0]; mul_b = cur_q[3]; end
      OP_SQ0: begin mul_a = mag[0]; mul_b = mag[0]; mul_big = big[0]; end
      OP_SQ1: begin mul_a = mag[1]; mul_b = mag[1]; mul_big = big[1]; end
      OP_SQ2: begin mul_a = mag[2]; mul_b = mag[2]; mul_big = big[2]; end
      OP_SQ3: begin mul_a = mag[3]; mul_b = mag[3]; mul_big = big[3]; end
      default: ;
    endcase
  end

  // Register the product and its operation tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_NONE;
    end else begin
      op_q <= cmd_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= mul_a * mul_b;
    big_q <= mul_big;
  end

  // Floor the fixed-point product
  assign pf    = p_q >>> FRACTION_BITS;
  assign pf2   = pf <<< 1;
  assign sum_d = sum_q + $unsigned(p_q);

  // Accumulate quaternion square plus C
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_init) begin
      acc_q[0] <= 64'(cfg_i.c_x);
      acc_q[1] <= 64'(cfg_i.c_y);
      acc_q[2] <= 64'(cfg_i.c_z);
      acc_q[3] <= 64'(cfg_i.c_w);
    end else begin
      unique case (op_q)
        OP_XX:  acc_q[0] <= acc_q[0] + pf;
        OP_YY:  acc_q[0] <= acc_q[0] - pf;
        OP_ZZ:  acc_q[0] <= acc_q[0] - pf;
        OP_WW:  acc_q[0] <= acc_q[0] - pf;
        OP_XY:  acc_q[1] <= acc_q[1] + pf2;
        OP_XZ:  acc_q[2] <= acc_q[2] + pf2;
        OP_XW:  acc_q[3] <= acc_q[3] + pf2;
        default: ;
      endcase
    end
  end

  // Accumulate the sum of squares, flag overflow of the norm range
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_clr) begin
      sum_q <= '0;
      sat_q <= 1'b0;
    end else if (op_q == OP_SQ0 || op_q == OP_SQ1 || op_q == OP_SQ2 ||
                 op_q == OP_SQ3) begin
      sum_q <= sum_d;
      sat_q <= sat_q | big_q | (sum_d[63:62] != 2'b00);
    end
  end

  qjem_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.root_start),
    .value_i (sum_q),
    .done_o  (root_done),
    .root_o  (root)
  );

  assign norm_val = sat_q ? NormMax : root;
  assign path_sum = {1'b0, path_q} + {1'b0, norm_val};
  assign path_d   = path_sum[31] ? NormMax : path_sum[30:0];

  // Hold the point, count, path and metric
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < 4; k++) begin
        start_q[k] <= in_z[k];
        cur_q[k]   <= in_z[k];
      end
      count_q  <= '0;
      path_q   <= '0;
      metric_q <= '0;
    end else begin
      if (cmd_i.cur_upd) begin
        for (int k = 0; k < 4; k++) begin
          prev_q[k] <= cur_q[k];
          cur_q[k]  <= sat32(acc_q[k]);
        end
        count_q <= count_q + 16'd1;
      end
      if (cmd_i.path_add) begin
        path_q <= path_d;
        if (cfg_i.metric_mode == MODE_PATH) begin
          metric_q <= path_d;
        end
      end
      if (cmd_i.metric_take) begin
        metric_q <= norm_val;
      end
    end
  end

  // Capture the result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_q.metric          <= metric_q;
      res_q.iterations_done <= count_q;
      res_q.escaped         <= (count_q != 16'd0) && (metric_q >= cfg_i.escape_level);
    end
  end

  assign sts_o.root_done = root_done;
  assign sts_o.limit_hit = count_q == cfg_i.iteration_limit;
  assign sts_o.esc_hit   = metric_q >= cfg_i.escape_level;
  assign out_data_o      = res_q;

endmodule

// ===== hw/rtl/qjem_ctrl.sv =====
// ---------------------------------------------------------------------------
// qjem_ctrl
// Sequencer: square-plus-C passes, norm passes, threshold check, output.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qjem_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  qjem_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  qjem_pkg::sts_t sts_i,
  output qjem_pkg::cmd_t cmd_o
);
  import qjem_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QMUL,
    ST_QDRAIN,
    ST_QUPD,
    ST_NSQ,
    ST_NDRAIN,
    ST_NSTART,
    ST_NROOT,
    ST_CHECK,
    ST_FIN
  } state_e;

  state_e      state_q;
  logic [2:0]  k_q;
  logic        tgt_q;
  nsrc_e       src_q;
  logic        out_valid_q;
  logic        in_fire;
  logic        res_free;

  assign in_ready_o = state_q == ST_IDLE;
  assign in_fire    = in_valid_i && in_ready_o;
  assign res_free   = !out_valid_q || out_ready_i;

  // Decode commands from the state
  always_comb begin
    cmd_o     = '0;
    cmd_o.op  = OP_NONE;
    cmd_o.src = src_q;
    unique case (state_q)
      ST_IDLE:  cmd_o.load = in_fire;
      ST_QMUL: begin
        cmd_o.op       = op_e'(4'(OP_XX) + 4'(k_q));
        cmd_o.acc_init = k_q == 3'd0;
      end
      ST_QUPD:  cmd_o.cur_upd = 1'b1;
      ST_NSQ: begin
        cmd_o.op      = op_e'(4'(OP_SQ0) + 4'(k_q));
        cmd_o.sum_clr = k_q == 3'd0;
      end
      ST_NSTART: cmd_o.root_start = 1'b1;
      ST_NROOT: begin
        cmd_o.metric_take = sts_i.root_done && tgt_q;
        cmd_o.path_add    = sts_i.root_done && !tgt_q;
      end
      ST_FIN:   cmd_o.res_load = res_free;
      default: ;
    endcase
  end

  // Hold state, step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      tgt_q       <= 1'b0;
      src_q       <= SRC_DIFF;
      out_valid_q <= 1'b0;
    end else begin
      // Drop valid once taken, unless the finish state reloads it
      if (out_valid_q && out_ready_i && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          k_q <= '0;
          if (in_fire) begin
            if (cfg_i.iteration_limit != 16'd0) begin
              state_q <= ST_QMUL;
            end else if (cfg_i.metric_mode >= MODE_MAG) begin
              state_q <= ST_NSQ;
              src_q   <= SRC_MAG;
              tgt_q   <= 1'b1;
            end else begin
              state_q <= ST_CHECK;
            end
          end
        end
        ST_QMUL: begin
          if (k_q == 3'd6) begin
            state_q <= ST_QDRAIN;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        ST_QDRAIN: state_q <= ST_QUPD;
        ST_QUPD: begin
          state_q <= ST_NSQ;
          k_q     <= '0;
          src_q   <= SRC_DIFF;
          tgt_q   <= 1'b0;
        end
        ST_NSQ: begin
          if (k_q == 3'd3) begin
            state_q <= ST_NDRAIN;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        ST_NDRAIN: state_q <= ST_NSTART;
        ST_NSTART: state_q <= ST_NROOT;
        ST_NROOT: begin
          if (sts_i.root_done) begin
            k_q <= '0;
            if (tgt_q || cfg_i.metric_mode == MODE_PATH) begin
              state_q <= ST_CHECK;
            end else begin
              state_q <= ST_NSQ;
              tgt_q   <= 1'b1;
              src_q   <= (cfg_i.metric_mode == MODE_DISP) ? SRC_DISP : SRC_MAG;
            end
          end
        end
        ST_CHECK: begin
          k_q <= '0;
          if (sts_i.esc_hit || sts_i.limit_hit) begin
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_QMUL;
          end
        end
        ST_FIN: begin
          if (res_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  `QJEM_ASSERT(a_valid_from_fin, $rose(out_valid_q) |-> $past(state_q == ST_FIN), "word shown outside finish")
  `QJEM_ASSERT(a_root_leaves, (state_q == ST_NROOT) && sts_i.root_done |=> state_q != ST_NROOT, "root wait stuck")
  `QJEM_ASSERT(a_accept_busy, in_fire |=> state_q != ST_IDLE, "accepted word not started")

endmodule

// ===== hw/rtl/quaternion_julia_escape_metric.sv =====
// ---------------------------------------------------------------------------
// quaternion_julia_escape_metric
// Iterates Z = Z*Z + C in signed fixed point and reports the selected
// escape measure, the iteration count and an escape flag.
// ---------------------------------------------------------------------------
//  channel | handshake                 | word
//  --------+---------------------------+-----------------------------------
//  in      | in_valid_i / in_ready_o   | in_data_i  (z_x, z_y, z_z, z_w)
//  out     | out_valid_o / out_ready_i | out_data_o (metric, iterations_done,
//          |                           |             escaped)
//  cfg     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One word at a time. Each iteration runs the square on the shared 32x32
// multiplier, then one norm in path mode and two otherwise (4 squares,
// drain, root start, root steps, take), plus the load, check and finish
// states; the root unit takes most of the time.
// Reset returns to idle with the documented register defaults.
// A result waiting on out_ready_i does not block the next input word.
// ---------------------------------------------------------------------------
module quaternion_julia_escape_metric #(
  parameter int unsigned FRACTION_BITS = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  qjem_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output qjem_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [31:0]    cfg_data_i
);
  import qjem_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.c_x             <= 32'sd5033165;
      cfg_q.c_y             <= 32'sd8388608;
      cfg_q.c_z             <= 32'sd6710886;
      cfg_q.c_w             <= 32'sd3355443;
      cfg_q.iteration_limit <= 16'd8;
      cfg_q.escape_level    <= 31'd67108864;
      cfg_q.metric_mode     <= MODE_PATH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_C_X:   cfg_q.c_x             <= cfg_data_i;
        CFG_C_Y:   cfg_q.c_y             <= cfg_data_i;
        CFG_C_Z:   cfg_q.c_z             <= cfg_data_i;
        CFG_C_W:   cfg_q.c_w             <= cfg_data_i;
        CFG_LIMIT: cfg_q.iteration_limit <= cfg_data_i[15:0];
        CFG_LEVEL: cfg_q.escape_level    <= cfg_data_i[30:0];
        CFG_MODE:  cfg_q.metric_mode     <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  qjem_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  qjem_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
